@@ src/ctpt_pkg.sv @@
// ----------------------------------------------------------------------------
// ctpt_pkg
// shared types, constants and helpers of the color target pixel tracker
// ----------------------------------------------------------------------------
package ctpt_pkg;

  localparam int COL_BITS  = 11;
  localparam int ROW_BITS  = 10;
  localparam int CNT_BITS  = 20;
  localparam int PIX_BITS  = 8;
  localparam int ADDR_BITS = 4;

  localparam logic [CNT_BITS-1:0] CNT_MAX     = {CNT_BITS{1'b1}};
  localparam logic [PIX_BITS-1:0] IMPROVE_MAX = {PIX_BITS{1'b1}};

  typedef enum logic {
    MODE_RED  = 1'b0,
    MODE_BLUE = 1'b1
  } mode_t;

  // register indexes (byte address / 4)
  localparam logic [1:0] REG_COLOR_MODE  = 2'd0;
  localparam logic [1:0] REG_RED_LIMIT   = 2'd1;
  localparam logic [1:0] REG_BLUE_LIMIT  = 2'd2;

  localparam logic [PIX_BITS-1:0] RED_LIMIT_RST  = 8'd100;
  localparam logic [PIX_BITS-1:0] BLUE_LIMIT_RST = 8'd10;
  localparam logic [PIX_BITS-1:0] MARK_RED       = 8'd255;

  typedef logic signed [10:0] sval_t;

  // red test thresholds
  localparam logic [PIX_BITS-1:0] RED_R_MIN = 8'd140;
  localparam sval_t RED_GB_MAX = 11'sd80;
  localparam sval_t RED_OFS    = 11'sd70;

  // blue test thresholds, two alternative windows
  localparam logic [PIX_BITS-1:0] BLUE_B_MIN_A = 8'd90;
  localparam sval_t BLUE_OFS_A    = 11'sd30;
  localparam sval_t BLUE_GR_MAX_A = 11'sd40;
  localparam logic [PIX_BITS-1:0] BLUE_B_MIN_C = 8'd120;
  localparam sval_t BLUE_OFS_C    = 11'sd60;
  localparam sval_t BLUE_GR_MAX_C = 11'sd80;

  typedef struct packed {
    logic                is_match;
    logic [PIX_BITS-1:0] mark;
    logic [PIX_BITS-1:0] bright;
  } pix_eval_t;

  // floor(s/3) for s < 768 (8-bit result) via reciprocal 683/2048
  function automatic logic [PIX_BITS-1:0] div3(input logic [9:0] s);
    logic [20:0] p;
    p = {11'b0, s} * {10'b0, 11'd683};
    return p[18:11];
  endfunction

endpackage

@@ src/ctpt_color_test.sv @@
// ----------------------------------------------------------------------------
// ctpt_color_test
// red / blue color tests, marker value and brightness of one pixel
// ----------------------------------------------------------------------------
module ctpt_color_test
  import ctpt_pkg::*;
(
  input  logic [PIX_BITS-1:0] r,
  input  logic [PIX_BITS-1:0] g,
  input  logic [PIX_BITS-1:0] b,
  input  mode_t               mode,
  output pix_eval_t           eval
);

  sval_t rs, gs, bs;
  sval_t avg_rb, avg_rg, diff_gb, diff_gr;
  logic  red_ok, blue_a, blue_c, blue_ok;
  logic [8:0] sum_rb, sum_rg;
  logic [9:0] sum_rgb;

  assign rs = sval_t'({3'b0, r});
  assign gs = sval_t'({3'b0, g});
  assign bs = sval_t'({3'b0, b});

  assign sum_rb  = {1'b0, r} + {1'b0, b};
  assign sum_rg  = {1'b0, r} + {1'b0, g};
  assign sum_rgb = {2'b0, r} + {2'b0, g} + {2'b0, b};

  assign avg_rb  = sval_t'({3'b0, sum_rb[8:1]});
  assign avg_rg  = sval_t'({3'b0, sum_rg[8:1]});
  assign diff_gb = gs - bs;
  assign diff_gr = gs - rs;

  assign red_ok = (r > RED_R_MIN) && (diff_gb < RED_GB_MAX) && (avg_rb < (rs - RED_OFS));
  assign blue_a = (avg_rg < (bs - BLUE_OFS_A)) && (b > BLUE_B_MIN_A)
                  && (diff_gr < BLUE_GR_MAX_A);
  assign blue_c = (avg_rg < (bs - BLUE_OFS_C)) && (b > BLUE_B_MIN_C)
                  && (diff_gr < BLUE_GR_MAX_C);
  assign blue_ok = blue_a || blue_c;

  always_comb begin
    eval.bright = div3(sum_rgb);
    case (mode)
      MODE_BLUE: begin
        eval.is_match = blue_ok;
        eval.mark     = blue_ok ? ({b[6:0], 1'b0} - g - r) : '0;
      end
      default: begin
        eval.is_match = red_ok;
        eval.mark     = red_ok ? MARK_RED : '0;
      end
    endcase
  end

endmodule

@@ src/color_target_pixel_tracker_top.sv @@
// ----------------------------------------------------------------------------
// color_target_pixel_tracker_top
// per-pixel color target test with peak, first-match and match tracking
// ----------------------------------------------------------------------------
// usage:
//   in channel: one pixel word per in_valid/in_ready handshake (rgb, x, y,
//   start_of_frame). out channel: one result word per pixel on
//   out_valid/out_ready, in input order.
//   a word accepted into the input register is evaluated there against the
//   tracking state and then lands in the output register, which presents its
//   result.
//   throughput: one pixel per cycle when not stalled; tracking state feeds back
//   over one register stage, so back to back pixels see each other's updates.
//   stall: while out_ready is low the result stays put and the input
//   register holds one more pixel; in_ready then drops until the result
//   moves on.
//   start_of_frame clears peak, first-match and counters before that pixel.
//   reset: rst clears valid flags and tracking state and sets the registers
//   to color_mode red, red limit 100, blue limit 10. the user must write the
//   registers over the apb port only while no pixel is in flight; not enforced.
// ----------------------------------------------------------------------------
module color_target_pixel_tracker_top
  import ctpt_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  // pixel in
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [PIX_BITS-1:0]  pix_red,
  input  logic [PIX_BITS-1:0]  pix_green,
  input  logic [PIX_BITS-1:0]  pix_blue,
  input  logic [COL_BITS-1:0]  pix_x,
  input  logic [ROW_BITS-1:0]  pix_y,
  input  logic                 start_of_frame,
  // result out
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 is_match,
  output logic [PIX_BITS-1:0]  mark_value,
  output logic                 target_found,
  output logic [COL_BITS-1:0]  peak_x,
  output logic [ROW_BITS-1:0]  peak_y,
  output logic [COL_BITS-1:0]  first_x,
  output logic [ROW_BITS-1:0]  first_y,
  output logic [CNT_BITS-1:0]  match_total,
  // config
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_BITS-1:0] paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  // config registers
  mode_t               color_mode;
  logic [PIX_BITS-1:0] red_improve_limit;
  logic [PIX_BITS-1:0] blue_improve_limit;
  logic                cfg_write;

  // input register
  logic                s1_valid;
  logic [PIX_BITS-1:0] s1_red, s1_green, s1_blue;
  logic [COL_BITS-1:0] s1_x;
  logic [ROW_BITS-1:0] s1_y;
  logic                s1_sof;
  logic                s1_advance;

  // tracking state
  logic [PIX_BITS-1:0] peak_brightness, peak_brightness_next;
  logic [PIX_BITS-1:0] improve_count, improve_count_next;
  logic [COL_BITS-1:0] peak_col, peak_col_next;
  logic [ROW_BITS-1:0] peak_row, peak_row_next;
  logic [COL_BITS-1:0] first_col, first_col_next;
  logic [ROW_BITS-1:0] first_row, first_row_next;
  logic [CNT_BITS-1:0] match_count, match_count_next;
  logic                found_next;

  pix_eval_t           eval;

  // ---------------- config port ----------------
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      color_mode         <= MODE_RED;
      red_improve_limit  <= RED_LIMIT_RST;
      blue_improve_limit <= BLUE_LIMIT_RST;
    end else if (cfg_write) begin
      unique case (paddr[3:2])
        REG_COLOR_MODE: color_mode         <= mode_t'(pwdata[0]);
        REG_RED_LIMIT:  red_improve_limit  <= pwdata[PIX_BITS-1:0];
        REG_BLUE_LIMIT: blue_improve_limit <= pwdata[PIX_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_COLOR_MODE: prdata = {31'b0, color_mode};
      REG_RED_LIMIT:  prdata = {24'b0, red_improve_limit};
      REG_BLUE_LIMIT: prdata = {24'b0, blue_improve_limit};
      default:        prdata = '0;
    endcase
  end

  // ---------------- input register ----------------
  assign s1_advance = s1_valid && (!out_valid || out_ready);
  assign in_ready   = !s1_valid || s1_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_red   <= pix_red;
      s1_green <= pix_green;
      s1_blue  <= pix_blue;
      s1_x     <= pix_x;
      s1_y     <= pix_y;
      s1_sof   <= start_of_frame;
    end
  end

  // ---------------- evaluation ----------------
  ctpt_color_test u_color_test (
    .r    (s1_red),
    .g    (s1_green),
    .b    (s1_blue),
    .mode (color_mode),
    .eval (eval)
  );

  always_comb begin
    if (s1_sof) begin
      peak_brightness_next = '0;
      improve_count_next   = '0;
      peak_col_next        = '0;
      peak_row_next        = '0;
      first_col_next       = '0;
      first_row_next       = '0;
      match_count_next     = '0;
    end else begin
      peak_brightness_next = peak_brightness;
      improve_count_next   = improve_count;
      peak_col_next        = peak_col;
      peak_row_next        = peak_row;
      first_col_next       = first_col;
      first_row_next       = first_row;
      match_count_next     = match_count;
    end
    if (eval.is_match) begin
      if (improve_count_next == '0) begin
        first_col_next = s1_x;
        first_row_next = s1_y;
      end
      if (match_count_next != CNT_MAX) begin
        match_count_next = match_count_next + 1'b1;
      end
      if (eval.bright > peak_brightness_next) begin
        peak_brightness_next = eval.bright;
        peak_col_next        = s1_x;
        peak_row_next        = s1_y;
        if (improve_count_next != IMPROVE_MAX) begin
          improve_count_next = improve_count_next + 1'b1;
        end
      end
    end
    case (color_mode)
      MODE_BLUE: found_next = improve_count_next >= blue_improve_limit;
      default:   found_next = improve_count_next > red_improve_limit;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      peak_brightness <= '0;
      improve_count   <= '0;
      peak_col        <= '0;
      peak_row        <= '0;
      first_col       <= '0;
      first_row       <= '0;
      match_count     <= '0;
    end else if (s1_advance) begin
      peak_brightness <= peak_brightness_next;
      improve_count   <= improve_count_next;
      peak_col        <= peak_col_next;
      peak_row        <= peak_row_next;
      first_col       <= first_col_next;
      first_row       <= first_row_next;
      match_count     <= match_count_next;
    end
  end

  // ---------------- result register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      is_match     <= eval.is_match;
      mark_value   <= eval.mark;
      target_found <= found_next;
      peak_x       <= peak_col_next;
      peak_y       <= peak_row_next;
      first_x      <= first_col_next;
      first_y      <= first_row_next;
      match_total  <= match_count_next;
    end
  end

  // ---------------- assertions ----------------
  a_no_mark_without_match : assert property (@(posedge clk) disable iff (rst)
    out_valid && !is_match |-> mark_value == '0)
    else $error("mark value set on a non-matching pixel");

  a_match_counted : assert property (@(posedge clk) disable iff (rst)
    out_valid && is_match |-> match_total != '0)
    else $error("matching pixel not counted");

  a_improve_le_match : assert property (@(posedge clk) disable iff (rst)
    match_count != CNT_MAX |-> {{(CNT_BITS-PIX_BITS){1'b0}}, improve_count} <= match_count)
    else $error("more peak improvements than matches");

  a_ready_when_out_free : assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with an empty result register");

endmodule

@@ dv/tb_color_target_pixel_tracker_top.sv @@
// ----------------------------------------------------------------------------
// tb_color_target_pixel_tracker_top
// self-checking bench for the color target pixel tracker: pixel words are
// pushed through the valid/ready input with random gaps, and a predictor
// of the red and blue tests, peak, first-match and match tracking builds
// the expected result words. Each result word is checked field by field.
// Directed cases cover the test windows, frame start, mode change within a
// frame and limit extremes, followed by random frames, random register
// settings and output back-pressure.
// ----------------------------------------------------------------------------
module tb_color_target_pixel_tracker_top;
  import ctpt_pkg::*;

  localparam int CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic                is_match;
    logic [PIX_BITS-1:0] mark;
    logic                found;
    logic [COL_BITS-1:0] pk_x;
    logic [ROW_BITS-1:0] pk_y;
    logic [COL_BITS-1:0] fm_x;
    logic [ROW_BITS-1:0] fm_y;
    logic [CNT_BITS-1:0] total;
  } track_word_t;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 in_valid;
  logic                 in_ready;
  logic [PIX_BITS-1:0]  pix_red;
  logic [PIX_BITS-1:0]  pix_green;
  logic [PIX_BITS-1:0]  pix_blue;
  logic [COL_BITS-1:0]  pix_x;
  logic [ROW_BITS-1:0]  pix_y;
  logic                 start_of_frame;
  logic                 out_valid;
  logic                 out_ready;
  logic                 is_match;
  logic [PIX_BITS-1:0]  mark_value;
  logic                 target_found;
  logic [COL_BITS-1:0]  peak_x;
  logic [ROW_BITS-1:0]  peak_y;
  logic [COL_BITS-1:0]  first_x;
  logic [ROW_BITS-1:0]  first_y;
  logic [CNT_BITS-1:0]  match_total;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [ADDR_BITS-1:0] paddr;
  logic [31:0]          pwdata;
  logic [31:0]          prdata;
  logic                 pready;

  color_target_pixel_tracker_top dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .pix_red        (pix_red),
    .pix_green      (pix_green),
    .pix_blue       (pix_blue),
    .pix_x          (pix_x),
    .pix_y          (pix_y),
    .start_of_frame (start_of_frame),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .is_match       (is_match),
    .mark_value     (mark_value),
    .target_found   (target_found),
    .peak_x         (peak_x),
    .peak_y         (peak_y),
    .first_x        (first_x),
    .first_y        (first_y),
    .match_total    (match_total),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  // register copies
  mode_t               cfg_mode     = MODE_RED;
  logic [PIX_BITS-1:0] cfg_red_lim  = 8'd100;
  logic [PIX_BITS-1:0] cfg_blue_lim = 8'd10;

  // tracking state copies
  logic [PIX_BITS-1:0] pk_bright = '0;
  logic [PIX_BITS-1:0] imp_cnt   = '0;
  logic [COL_BITS-1:0] pk_col    = '0;
  logic [ROW_BITS-1:0] pk_row    = '0;
  logic [COL_BITS-1:0] fm_col    = '0;
  logic [ROW_BITS-1:0] fm_row    = '0;
  logic [CNT_BITS-1:0] hits      = '0;

  track_word_t expected_words[$];
  int          mismatches  = 0;
  int unsigned cycles      = 0;
  int          hold_cycles = 0;
  int          rx_stall    = 0;
  bit          idle_off    = 1'b0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb_color_target_pixel_tracker_top: done, errors");
      $finish;
    end
  end

  function automatic int pick_gap();
    int p;
    if (idle_off) return 0;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 88) return $urandom_range(1, 3);
    if (p < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic track_word_t track_pixel(input logic [7:0] r, input logic [7:0] g,
                                              input logic [7:0] b, input logic [COL_BITS-1:0] x,
                                              input logic [ROW_BITS-1:0] y, input logic sof);
    int          ri, gi, bi, avg;
    logic        hit;
    logic [7:0]  mark;
    logic [7:0]  bright;
    track_word_t w;
    ri = r;
    gi = g;
    bi = b;
    if (sof) begin
      pk_bright = '0;
      imp_cnt   = '0;
      pk_col    = '0;
      pk_row    = '0;
      fm_col    = '0;
      fm_row    = '0;
      hits      = '0;
    end
    mark = '0;
    if (cfg_mode == MODE_RED) begin
      hit = (ri > 140) && ((gi - bi) < 80) && (((ri + bi) / 2) < (ri - 70));
      if (hit) mark = 8'd255;
    end else begin
      avg = (ri + gi) / 2;
      hit = ((avg < bi - 30) && (bi > 90) && ((gi - ri) < 40)) ||
            ((avg < bi - 60) && (bi > 120) && ((gi - ri) < 80));
      if (hit) mark = 8'(2 * bi - gi - ri);
    end
    if (hit) begin
      bright = 8'((ri + gi + bi) / 3);
      if (imp_cnt == 0) begin
        fm_col = x;
        fm_row = y;
      end
      if (hits != {CNT_BITS{1'b1}}) hits = hits + 1'b1;
      if (bright > pk_bright) begin
        pk_bright = bright;
        pk_col    = x;
        pk_row    = y;
        if (imp_cnt != 8'hff) imp_cnt = imp_cnt + 1'b1;
      end
    end
    w.is_match = hit;
    w.mark     = mark;
    w.found    = (cfg_mode == MODE_RED) ? (imp_cnt > cfg_red_lim) : (imp_cnt >= cfg_blue_lim);
    w.pk_x     = pk_col;
    w.pk_y     = pk_row;
    w.fm_x     = fm_col;
    w.fm_y     = fm_row;
    w.total    = hits;
    return w;
  endfunction

  task automatic check_field(input string fname, input longint unsigned want,
                             input longint unsigned got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch %s: expected %0d, got %0d", fname, want, got);
    end
  endtask

  // result side: random stalls plus an optional long hold-off
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      out_ready   <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else if (rx_stall > 0) begin
      out_ready <= 1'b0;
      rx_stall  <= rx_stall - 1;
    end else if (idle_off || $urandom_range(0, 3) != 0) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= 1'b0;
      rx_stall  <= pick_gap();
    end
  end

  always @(posedge clk) begin
    track_word_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_words.size() == 0) begin
        check_field("unexpected word", 0, 1);
      end else begin
        want = expected_words.pop_front();
        check_field("is_match", want.is_match, is_match);
        check_field("mark_value", want.mark, mark_value);
        check_field("target_found", want.found, target_found);
        check_field("peak_x", want.pk_x, peak_x);
        check_field("peak_y", want.pk_y, peak_y);
        check_field("first_x", want.fm_x, first_x);
        check_field("first_y", want.fm_y, first_y);
        check_field("match_total", want.total, match_total);
      end
    end
  end

  task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                            input logic [COL_BITS-1:0] x, input logic [ROW_BITS-1:0] y,
                            input logic sof);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    pix_red        <= r;
    pix_green      <= g;
    pix_blue       <= b;
    pix_x          <= x;
    pix_y          <= y;
    start_of_frame <= sof;
    do @(posedge clk); while (!in_ready);
    expected_words.push_back(track_pixel(r, g, b, x, y, sof));
  endtask

  task automatic send_random_pixel(input logic sof);
    int kind, r, g, b;
    kind = $urandom_range(0, 9);
    if (kind < 4) begin
      r = $urandom_range(139, 255);
      b = $urandom_range(0, (r > 139) ? r - 139 : 0);
      g = $urandom_range(0, (b + 81 > 255) ? 255 : b + 81);
    end else if (kind < 8) begin
      b = $urandom_range(86, 255);
      r = $urandom_range(0, 70);
      g = $urandom_range(0, r + 85);
    end else begin
      r = $urandom_range(0, 255);
      g = $urandom_range(0, 255);
      b = $urandom_range(0, 255);
    end
    send_pixel(r[7:0], g[7:0], b[7:0], COL_BITS'($urandom_range(0, 2047)),
               ROW_BITS'($urandom_range(0, 1023)), sof);
  endtask

  task automatic drain_results;
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic apb_xfer(input logic wr, input logic [1:0] idx, input logic [31:0] wdata,
                          output logic [31:0] rdata);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_reg(input logic [1:0] idx, input logic [31:0] want);
    logic [31:0] rd;
    apb_xfer(1'b0, idx, '0, rd);
    check_field("register readback", want, rd);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    logic [31:0] rd;
    apb_xfer(1'b1, idx, val, rd);
    case (idx)
      REG_COLOR_MODE: cfg_mode = mode_t'(val[0]);
      REG_RED_LIMIT:  cfg_red_lim = val[7:0];
      default:        cfg_blue_lim = val[7:0];
    endcase
    check_reg(idx, val);
  endtask

  function automatic logic [31:0] pick_limit();
    int p;
    p = $urandom_range(0, 99);
    if (p < 20) return 32'd0;
    if (p < 35) return 32'd255;
    if (p < 85) return $urandom_range(0, 12);
    return $urandom_range(0, 255);
  endfunction

  task automatic test_register_defaults;
    check_reg(REG_COLOR_MODE, MODE_RED);
    check_reg(REG_RED_LIMIT, 32'd100);
    check_reg(REG_BLUE_LIMIT, 32'd10);
  endtask

  task automatic test_red_window;
    send_pixel(8'd0, 8'd0, 8'd0, 11'd0, 10'd0, 1'b1);
    send_pixel(8'd255, 8'd255, 8'd255, 11'd2047, 10'd1023, 1'b0);
    send_pixel(8'd141, 8'd0, 8'd0, 11'd5, 10'd6, 1'b0);
    send_pixel(8'd140, 8'd0, 8'd0, 11'd7, 10'd8, 1'b0);
    send_pixel(8'd200, 8'd138, 8'd59, 11'd100, 10'd200, 1'b0);
    send_pixel(8'd200, 8'd139, 8'd59, 11'd101, 10'd201, 1'b0);
    send_pixel(8'd200, 8'd0, 8'd60, 11'd102, 10'd202, 1'b0);
    send_pixel(8'd255, 8'd193, 8'd114, 11'h555, 10'h2aa, 1'b0);
    // frame start in the middle of a run of matches
    send_pixel(8'd255, 8'd0, 8'd0, 11'h2aa, 10'h155, 1'b1);
    drain_results;
  endtask

  task automatic test_blue_window;
    write_reg(REG_COLOR_MODE, MODE_BLUE);
    send_pixel(8'd0, 8'd0, 8'd91, 11'd10, 10'd11, 1'b1);
    send_pixel(8'd0, 8'd0, 8'd90, 11'd12, 10'd13, 1'b0);
    send_pixel(8'd0, 8'd40, 8'd200, 11'd14, 10'd15, 1'b0);
    send_pixel(8'd0, 8'd80, 8'd255, 11'd16, 10'd17, 1'b0);
    send_pixel(8'd60, 8'd0, 8'd91, 11'd18, 10'd19, 1'b0);
    send_pixel(8'd0, 8'd0, 8'd255, 11'd2047, 10'd1023, 1'b0);
    send_pixel(8'd255, 8'd255, 8'd255, 11'd20, 10'd21, 1'b0);
    drain_results;
  endtask

  // state carries over a mode change, matches of both tests are counted
  task automatic test_mode_switch;
    write_reg(REG_COLOR_MODE, MODE_RED);
    send_pixel(8'd255, 8'd0, 8'd0, 11'd30, 10'd31, 1'b0);
    send_pixel(8'd255, 8'd100, 8'd30, 11'd32, 10'd33, 1'b0);
    drain_results;
    write_reg(REG_COLOR_MODE, MODE_BLUE);
    send_pixel(8'd0, 8'd0, 8'd255, 11'd34, 10'd35, 1'b0);
    drain_results;
  endtask

  task automatic test_limit_extremes;
    write_reg(REG_COLOR_MODE, MODE_RED);
    write_reg(REG_RED_LIMIT, 32'd0);
    send_pixel(8'd141, 8'd0, 8'd0, 11'd40, 10'd41, 1'b1);
    drain_results;
    write_reg(REG_RED_LIMIT, 32'd255);
    send_pixel(8'd0, 8'd0, 8'd0, 11'd42, 10'd43, 1'b0);
    drain_results;
    write_reg(REG_COLOR_MODE, MODE_BLUE);
    write_reg(REG_BLUE_LIMIT, 32'd0);
    send_pixel(8'd0, 8'd0, 8'd0, 11'd44, 10'd45, 1'b1);
    drain_results;
    write_reg(REG_BLUE_LIMIT, 32'd255);
    send_pixel(8'd0, 8'd0, 8'd0, 11'd46, 10'd47, 1'b0);
    drain_results;
  endtask

  // long output hold-off while words keep coming, fills the pipe
  task automatic test_output_holdoff;
    idle_off = 1'b1;
    hold_cycles <= 300;
    for (int i = 0; i < 40; i++) send_random_pixel(i == 0);
    idle_off = 1'b0;
    drain_results;
  endtask

  task automatic test_random_frames;
    int sent, frame_len;
    sent = 0;
    while (sent < 400) begin
      if ($urandom_range(0, 3) == 0) begin
        drain_results;
        if ($urandom_range(0, 1)) write_reg(REG_COLOR_MODE, $urandom_range(0, 1));
        if ($urandom_range(0, 1)) write_reg(REG_RED_LIMIT, pick_limit());
        if ($urandom_range(0, 1)) write_reg(REG_BLUE_LIMIT, pick_limit());
      end
      idle_off = ($urandom_range(0, 7) == 0);
      frame_len = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 20);
      for (int i = 0; i < frame_len; i++)
        send_random_pixel((i == 0) ? ($urandom_range(0, 4) != 0) : ($urandom_range(0, 49) == 0));
      sent += frame_len;
    end
    idle_off = 1'b0;
    drain_results;
  endtask

  initial begin
    rst            <= 1'b1;
    in_valid       <= 1'b0;
    pix_red        <= '0;
    pix_green      <= '0;
    pix_blue       <= '0;
    pix_x          <= '0;
    pix_y          <= '0;
    start_of_frame <= 1'b0;
    out_ready      <= 1'b0;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= '0;
    pwdata         <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_register_defaults;
    test_red_window;
    test_blue_window;
    test_mode_switch;
    test_limit_extremes;
    test_output_holdoff;
    test_random_frames;
    drain_results;
    repeat (8) @(posedge clk);
    if (mismatches == 0 && expected_words.size() == 0) begin
      $display("tb_color_target_pixel_tracker_top: done, clean");
    end else begin
      $display("tb_color_target_pixel_tracker_top: done, errors");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
src/ctpt_pkg.sv
src/ctpt_color_test.sv
src/color_target_pixel_tracker_top.sv
dv/tb_color_target_pixel_tracker_top.sv
